[hdl/hcrc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// hcrc_pkg: shared types and constants of the CONNECT reply checker
// Byte class token, result record, outcome codes and register indexes.
// ============================================================================
package hcrc_pkg;

    localparam int unsigned LINE_LEN_W  = 16;
    localparam int unsigned HDR_CNT_W   = 8;
    localparam int unsigned HDR_BYTES_W = 21;
    localparam int unsigned CFG_DATA_W  = 21;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned STATUS_W    = 10;

    localparam logic [LINE_LEN_W-1:0]  MAX_LINE_RST  = 16'd8192;
    localparam logic [HDR_CNT_W-1:0]   MAX_COUNT_RST = 8'd100;
    localparam logic [HDR_BYTES_W-1:0] MAX_BYTES_RST = 21'd65536;

    localparam logic [LINE_LEN_W-1:0] PREFIX_LEN   = 16'd7;
    localparam logic [LINE_LEN_W-1:0] POS_MINOR    = 16'd7;
    localparam logic [LINE_LEN_W-1:0] POS_SPACE    = 16'd8;
    localparam logic [LINE_LEN_W-1:0] POS_LAST_DIG = 16'd11;
    localparam logic [LINE_LEN_W-1:0] POS_END      = 16'd12;
    localparam logic [LINE_LEN_W-1:0] MIN_STATUS   = 16'd12;
    localparam logic [LINE_LEN_W-1:0] BLANK_LEN    = 16'd2;
    localparam logic [STATUS_W-1:0]   STATUS_OK    = 10'd200;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_LINE  = 2'd0,
        REG_MAX_COUNT = 2'd1,
        REG_MAX_BYTES = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        OUT_OK        = 3'd0,
        OUT_REFUSED   = 3'd1,
        OUT_BAD_LINE  = 3'd2,
        OUT_TOO_LONG  = 3'd3,
        OUT_TOO_LARGE = 3'd4,
        OUT_TOO_MANY  = 3'd5,
        OUT_READ_FAIL = 3'd6
    } outcome_t;

    typedef struct packed {
        logic [7:0] data;
        logic       abort;
        logic       is_cr;
        logic       is_lf;
        logic       is_space;
        logic       is_digit;
    } token_t;

    typedef struct packed {
        outcome_t              outcome;
        logic [STATUS_W-1:0]   status_code;
    } result_t;

    // Expected characters of "HTTP/1." by position.
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                3'd0:    ch = 8'h48;
                3'd1:    ch = 8'h54;
                3'd2:    ch = 8'h54;
                3'd3:    ch = 8'h50;
                3'd4:    ch = 8'h2F;
                3'd5:    ch = 8'h31;
                3'd6:    ch = 8'h2E;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

[hdl/hcrc_fifo.sv]
`timescale 1ns / 1ps
// ============================================================================
// hcrc_fifo: small register queue
// Holds DEPTH entries of WIDTH bits with separate push and pop sides.
// ============================================================================
module hcrc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hdl/hcrc_front.sv]
`timescale 1ns / 1ps
// ============================================================================
// hcrc_front: byte classifier
// Accepts received bytes and tags them with the character classes the
// line parser needs, then queues the token for the back end.
// ============================================================================
module hcrc_front
    import hcrc_pkg::*;
(
    input  logic       push,
    input  logic [7:0] rx_byte,
    input  logic       abort,
    input  logic       q_full,
    output logic       q_push,
    output token_t     q_data
);

    always_comb
    begin
        q_data.data     = rx_byte;
        q_data.abort    = abort;
        q_data.is_cr    = (rx_byte == CH_CR);
        q_data.is_lf    = (rx_byte == CH_LF);
        q_data.is_space = (rx_byte == CH_SPACE);
        q_data.is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    end

    assign q_push = push && !q_full;

endmodule

[hdl/hcrc_back.sv]
`timescale 1ns / 1ps
// ============================================================================
// hcrc_back: line parser and limit checker
// Consumes classified bytes, tracks line and header state, holds the
// configuration registers and issues one result per finished reply.
// ============================================================================
module hcrc_back
    import hcrc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  tok_valid,
    input  token_t                tok,
    output logic                  tok_take,
    input  logic                  res_space,
    output logic                  res_valid,
    output result_t               res
);

    logic [LINE_LEN_W-1:0]  max_line_reg;
    logic [HDR_CNT_W-1:0]   max_count_reg;
    logic [HDR_BYTES_W-1:0] max_bytes_reg;

    logic                   in_headers_reg, in_headers_next;
    logic [LINE_LEN_W-1:0]  line_bytes_reg, line_bytes_next;
    logic                   last_cr_reg, last_cr_next;
    logic                   good_reg, good_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [HDR_CNT_W-1:0]   lines_reg, lines_next;
    logic [HDR_BYTES_W-1:0] total_reg, total_next;

    logic                   good;
    logic [STATUS_W-1:0]    status_val;
    logic [13:0]            status_prod;
    logic                   line_done;
    logic [LINE_LEN_W-1:0]  len;
    logic [HDR_BYTES_W:0]   sum;
    logic                   done;

    assign tok_take = tok_valid && res_space;
    assign len      = line_bytes_reg + 1'b1;
    assign sum      = {1'b0, total_reg} + {{(HDR_BYTES_W + 1 - LINE_LEN_W){1'b0}}, len};
    assign status_prod = {4'b0, status_reg} * 14'd10 + {10'b0, tok.data[3:0]};

    always_comb
    begin
        in_headers_next = in_headers_reg;
        line_bytes_next = line_bytes_reg;
        last_cr_next    = last_cr_reg;
        good_next       = good_reg;
        status_next     = status_reg;
        lines_next      = lines_reg;
        total_next      = total_reg;
        good            = good_reg;
        status_val      = status_reg;
        line_done       = 1'b0;
        done            = 1'b0;
        res.outcome     = OUT_OK;
        res.status_code = '0;

        if (tok_take)
        begin
            if (tok.abort)
            begin
                done        = 1'b1;
                res.outcome = OUT_READ_FAIL;
            end
            else if (line_bytes_reg >= max_line_reg)
            begin
                done        = 1'b1;
                res.outcome = OUT_TOO_LONG;
            end
            else
            begin
                // The status line is checked one position at a time.
                if (!in_headers_reg)
                begin
                    if (line_bytes_reg < PREFIX_LEN)
                    begin
                        if (tok.data != prefix_char(line_bytes_reg[2:0]))
                        begin
                            good = 1'b0;
                        end
                    end
                    else if (line_bytes_reg == POS_MINOR)
                    begin
                        if (tok.data != CH_ZERO && tok.data != CH_ONE)
                        begin
                            good = 1'b0;
                        end
                    end
                    else if (line_bytes_reg == POS_SPACE)
                    begin
                        if (!tok.is_space)
                        begin
                            good = 1'b0;
                        end
                    end
                    else if (line_bytes_reg <= POS_LAST_DIG)
                    begin
                        if (tok.is_digit)
                        begin
                            status_val = status_prod[STATUS_W-1:0];
                        end
                        else
                        begin
                            good = 1'b0;
                        end
                    end
                    else if (line_bytes_reg == POS_END)
                    begin
                        if (!tok.is_space && !tok.is_cr)
                        begin
                            good = 1'b0;
                        end
                    end
                end

                line_done   = last_cr_reg && tok.is_lf;
                good_next   = good;
                status_next = status_val;

                if (!line_done)
                begin
                    line_bytes_next = len;
                    last_cr_next    = tok.is_cr;
                end
                else
                begin
                    line_bytes_next = '0;
                    last_cr_next    = 1'b0;
                    if (!in_headers_reg)
                    begin
                        if (!good || len < MIN_STATUS)
                        begin
                            done        = 1'b1;
                            res.outcome = OUT_BAD_LINE;
                        end
                        else
                        begin
                            in_headers_next = 1'b1;
                        end
                    end
                    else if (sum > {1'b0, max_bytes_reg})
                    begin
                        done        = 1'b1;
                        res.outcome = OUT_TOO_LARGE;
                    end
                    else
                    begin
                        total_next = sum[HDR_BYTES_W-1:0];
                        if (len == BLANK_LEN)
                        begin
                            done            = 1'b1;
                            res.outcome     = (status_reg == STATUS_OK) ? OUT_OK : OUT_REFUSED;
                            res.status_code = status_reg;
                        end
                        else if (lines_reg >= max_count_reg)
                        begin
                            done        = 1'b1;
                            res.outcome = OUT_TOO_MANY;
                        end
                        else
                        begin
                            lines_next = lines_reg + 1'b1;
                        end
                    end
                end
            end
        end

        // Any result ends the reply and the parser waits for a new one.
        if (done)
        begin
            in_headers_next = 1'b0;
            line_bytes_next = '0;
            last_cr_next    = 1'b0;
            good_next       = 1'b1;
            status_next     = '0;
            lines_next      = '0;
            total_next      = '0;
        end
    end

    assign res_valid = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_headers_reg <= 1'b0;
            line_bytes_reg <= '0;
            last_cr_reg    <= 1'b0;
            good_reg       <= 1'b1;
            status_reg     <= '0;
            lines_reg      <= '0;
            total_reg      <= '0;
        end
        else
        begin
            in_headers_reg <= in_headers_next;
            line_bytes_reg <= line_bytes_next;
            last_cr_reg    <= last_cr_next;
            good_reg       <= good_next;
            status_reg     <= status_next;
            lines_reg      <= lines_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg  <= MAX_LINE_RST;
            max_count_reg <= MAX_COUNT_RST;
            max_bytes_reg <= MAX_BYTES_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_LINE:  max_line_reg  <= cfg_data[LINE_LEN_W-1:0];
                REG_MAX_COUNT: max_count_reg <= cfg_data[HDR_CNT_W-1:0];
                REG_MAX_BYTES: max_bytes_reg <= cfg_data[HDR_BYTES_W-1:0];
                default:       ;
            endcase
        end
    end

    a_abort_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        tok_take && tok.abort |=> line_bytes_reg == '0 && !in_headers_reg)
        else $error("abort did not restart the parser");

    a_headers_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_headers_reg |-> lines_reg == '0 && total_reg == '0)
        else $error("header counters set while awaiting the status line");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg < 10'd1000)
        else $error("status value beyond three digits");

endmodule

[hdl/http_connect_response_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// http_connect_response_checker: CONNECT proxy reply checker
// Splits a byte stream into CRLF lines, validates the status line and
// enforces line, header count and header size limits.
//
//   Channel  Handshake     Payload
//   input    push / full   rx_byte, abort
//   result   empty / pop   outcome, status_code
//   config   cfg_write     cfg_index, cfg_data
//
// One byte is accepted per cycle; the classifier feeds a token queue and
// the parser retires one token per cycle.
// Each result is registered in the result queue ahead of the result ports.
// The parser stalls only when the result queue is full; the input side
// stalls only when the token queue is full.
// Reset clears both queues and restores the register defaults.
// ============================================================================
module http_connect_response_checker
    import hcrc_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            rx_byte,
    input  logic                  abort,
    output logic                  empty,
    input  logic                  pop,
    output logic [2:0]            outcome,
    output logic [STATUS_W-1:0]   status_code,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    token_t  tok_in;
    token_t  tok_out;
    logic    tok_push;
    logic    tok_empty;
    logic    tok_take;
    logic    res_full;
    logic    res_valid;
    result_t res_in;
    result_t res_out;

    hcrc_front u_front (
        .push    (push),
        .rx_byte (rx_byte),
        .abort   (abort),
        .q_full  (full),
        .q_push  (tok_push),
        .q_data  (tok_in)
    );

    hcrc_fifo #(
        .WIDTH ($bits(token_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_tok_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .wdata (tok_in),
        .full  (full),
        .pop   (tok_take),
        .rdata (tok_out),
        .empty (tok_empty)
    );

    hcrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tok_valid (!tok_empty),
        .tok       (tok_out),
        .tok_take  (tok_take),
        .res_space (!res_full),
        .res_valid (res_valid),
        .res       (res_in)
    );

    hcrc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign outcome     = res_out.outcome;
    assign status_code = res_out.status_code;

endmodule
